FILE: rtl/magic_length_crc8_deframer_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the sync-word deframer
// Clocked on clk, disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef MAGIC_LENGTH_CRC8_DEFRAMER_ASSERT_SVH
`define MAGIC_LENGTH_CRC8_DEFRAMER_ASSERT_SVH
`ifndef NO_ASSERTIONS
// cons must hold in the same cycle as ante
`define MLCD_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("deframer assertion failed");
// cons must hold in the cycle after ante
`define MLCD_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("deframer assertion failed");
`else
`define MLCD_ASSERT_SAME(label, ante, cons)
`define MLCD_ASSERT_NEXT(label, ante, cons)
`endif
`endif

FILE: rtl/mlcd_pkg.sv
// ----------------------------------------------------------------------------
// mlcd_pkg
// Types and constants shared by the deframer modules, and the CRC-8 byte update used by mlcd_core.
// ----------------------------------------------------------------------------
package mlcd_pkg;

  localparam logic [7:0]  SYNC_FIRST  = 8'hA5;
  localparam logic [7:0]  SYNC_SECOND = 8'h5A;
  localparam logic [7:0]  CRC_POLY    = 8'h07;
  localparam logic [7:0]  CRC_TOP     = 8'h80;

  localparam logic [15:0] MAX_LEN_RESET = 16'd5120;

  localparam int          CFG_ADDR_W       = 2;
  localparam logic [1:0]  CFG_MAX_LEN_ADDR = 2'd0;

  typedef enum logic [2:0] {
    PH_HUNT0   = 3'd0,
    PH_HUNT1   = 3'd1,
    PH_LEN_LO  = 3'd2,
    PH_LEN_HI  = 3'd3,
    PH_PAYLOAD = 3'd4,
    PH_CRC     = 3'd5
  } phase_t;

  typedef enum logic [1:0] {
    EV_BYTE     = 2'd0,
    EV_GOOD     = 2'd1,
    EV_CRC_BAD  = 2'd2,
    EV_TOO_LONG = 2'd3
  } event_t;

  typedef struct packed {
    event_t      kind;
    logic [7:0]  data;
    logic [15:0] len;
  } result_t;

  // MSB-first CRC-8 update of one byte, eight shift steps
  function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] c;
    c = crc ^ b;
    for (int k = 0; k < 8; k++) begin
      if ((c & CRC_TOP) != 8'h00) begin
        c = (c << 1) ^ CRC_POLY;
      end else begin
        c = c << 1;
      end
    end
    return c;
  endfunction

endpackage

FILE: rtl/mlcd_cfg.sv
// ----------------------------------------------------------------------------
// mlcd_cfg
// APB register file holding the maximum payload length.
// ----------------------------------------------------------------------------
module mlcd_cfg
  import mlcd_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [31:0]           pwdata,
  output logic [31:0]           prdata,
  output logic                  pready,
  output logic [15:0]           max_len
);

  logic [15:0] max_len_r;
  logic        wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_len_r <= MAX_LEN_RESET;
    end else if (wr_en && (paddr == CFG_MAX_LEN_ADDR)) begin
      max_len_r <= pwdata[15:0];
    end
  end

  always_comb begin
    unique case (paddr)
      CFG_MAX_LEN_ADDR: prdata = {16'h0000, max_len_r};
      default:          prdata = 32'h0000_0000;
    endcase
  end

  assign max_len = max_len_r;

endmodule

FILE: rtl/mlcd_core.sv
// ----------------------------------------------------------------------------
// mlcd_core
// Input register and frame state: sync hunt, length, payload count, CRC-8.
// ----------------------------------------------------------------------------
`include "magic_length_crc8_deframer_assert.svh"
module mlcd_core
  import mlcd_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_rx_byte,
  input  logic        in_link_down,
  input  logic [15:0] max_len,
  input  logic        out_ready,
  output logic        res_load,
  output result_t     res
);

  logic        s1_valid_r, s1_valid_nxt;
  logic [7:0]  s1_byte_r;
  logic        s1_down_r;
  logic        accept;
  logic        advance;

  phase_t      phase_r, phase_nxt;
  logic [7:0]  len_lo_r, len_lo_nxt;
  logic [15:0] frame_len_r, frame_len_nxt;
  logic [15:0] bytes_left_r, bytes_left_nxt;
  logic [7:0]  crc_r, crc_nxt;
  logic [7:0]  crc_upd;
  logic        emit;
  event_t      kind;

  assign in_stall = s1_valid_r && !out_ready;
  assign accept   = in_valid && !in_stall;
  assign advance  = s1_valid_r && out_ready;

  always_comb begin
    if (accept) begin
      s1_valid_nxt = 1'b1;
    end else if (advance) begin
      s1_valid_nxt = 1'b0;
    end else begin
      s1_valid_nxt = s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_byte_r <= in_rx_byte;
      s1_down_r <= in_link_down;
    end
  end

  // the first length byte restarts the CRC from zero
  assign crc_upd = crc8_byte((phase_r == PH_LEN_LO) ? 8'h00 : crc_r, s1_byte_r);

  // next state
  always_comb begin
    phase_nxt      = phase_r;
    len_lo_nxt     = len_lo_r;
    frame_len_nxt  = frame_len_r;
    bytes_left_nxt = bytes_left_r;
    crc_nxt        = crc_r;
    if (s1_down_r) begin
      phase_nxt = PH_HUNT0;
    end else begin
      unique case (phase_r)
        PH_HUNT1: begin
          if (s1_byte_r == SYNC_SECOND) begin
            phase_nxt = PH_LEN_LO;
          end else if (s1_byte_r == SYNC_FIRST) begin
            phase_nxt = PH_HUNT1;
          end else begin
            phase_nxt = PH_HUNT0;
          end
        end
        PH_LEN_LO: begin
          len_lo_nxt = s1_byte_r;
          crc_nxt    = crc_upd;
          phase_nxt  = PH_LEN_HI;
        end
        PH_LEN_HI: begin
          frame_len_nxt = {s1_byte_r, len_lo_r};
          crc_nxt       = crc_upd;
          if (frame_len_nxt > max_len) begin
            phase_nxt = PH_HUNT0;
          end else begin
            bytes_left_nxt = frame_len_nxt;
            phase_nxt      = (frame_len_nxt == 16'h0000) ? PH_CRC : PH_PAYLOAD;
          end
        end
        PH_PAYLOAD: begin
          crc_nxt        = crc_upd;
          bytes_left_nxt = bytes_left_r - 16'd1;
          if (bytes_left_nxt == 16'h0000) begin
            phase_nxt = PH_CRC;
          end
        end
        PH_CRC: begin
          phase_nxt = PH_HUNT0;
        end
        default: begin
          phase_nxt = (s1_byte_r == SYNC_FIRST) ? PH_HUNT1 : PH_HUNT0;
        end
      endcase
    end
  end

  // outputs
  always_comb begin
    emit = 1'b0;
    kind = EV_BYTE;
    if (!s1_down_r) begin
      unique case (phase_r)
        PH_LEN_HI: begin
          emit = ({s1_byte_r, len_lo_r} > max_len);
          kind = EV_TOO_LONG;
        end
        PH_PAYLOAD: begin
          emit = 1'b1;
          kind = EV_BYTE;
        end
        PH_CRC: begin
          emit = 1'b1;
          kind = (s1_byte_r == crc_r) ? EV_GOOD : EV_CRC_BAD;
        end
        default: begin
          emit = 1'b0;
          kind = EV_BYTE;
        end
      endcase
    end
  end

  assign res_load  = advance && emit;
  assign res.kind  = kind;
  assign res.data  = (kind == EV_BYTE) ? s1_byte_r : 8'h00;
  assign res.len   = frame_len_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= PH_HUNT0;
      len_lo_r     <= 8'h00;
      frame_len_r  <= 16'h0000;
      bytes_left_r <= 16'h0000;
      crc_r        <= 8'h00;
    end else if (advance) begin
      phase_r      <= phase_nxt;
      len_lo_r     <= len_lo_nxt;
      frame_len_r  <= frame_len_nxt;
      bytes_left_r <= bytes_left_nxt;
      crc_r        <= crc_nxt;
    end
  end

  `MLCD_ASSERT_SAME(a_payload_left, phase_r == PH_PAYLOAD, bytes_left_r != 16'h0000)
  `MLCD_ASSERT_NEXT(a_down_hunt, advance && s1_down_r, phase_r == PH_HUNT0)
  `MLCD_ASSERT_NEXT(a_crc_end, advance && !s1_down_r && phase_r == PH_CRC, phase_r == PH_HUNT0)

endmodule

FILE: rtl/mlcd_out.sv
// ----------------------------------------------------------------------------
// mlcd_out
// Result register of the deframer; takes a new result whenever it drains.
// ----------------------------------------------------------------------------
module mlcd_out
  import mlcd_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        res_load,
  input  result_t     res,
  output logic        out_ready,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_event_kind,
  output logic [7:0]  out_out_byte,
  output logic [15:0] out_frame_length
);

  logic    out_valid_r, out_valid_nxt;
  result_t res_r;

  assign out_ready = !out_valid_r || !out_stall;

  always_comb begin
    if (out_ready) begin
      out_valid_nxt = res_load;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      res_r <= res;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_event_kind   = res_r.kind;
  assign out_out_byte     = res_r.data;
  assign out_frame_length = res_r.len;

endmodule

FILE: rtl/magic_length_crc8_deframer.sv
// One received byte per transfer in, one event per transfer out. The block takes a
// byte every cycle while in_stall is low and delivers its event (payload byte, frame
// good, CRC mismatch, length too large) through the input register and then the
// result register. Hunt bytes, length bytes that pass and link-down bytes give no
// event. A stall on the result side holds the input side only once both registers
// are full.
// ----------------------------------------------------------------------------
// magic_length_crc8_deframer
// Sync-word / length / CRC-8 deframer with an APB maximum-length register.
// ----------------------------------------------------------------------------
module magic_length_crc8_deframer
  import mlcd_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [7:0]            in_rx_byte,
  input  logic                  in_link_down,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [1:0]            out_event_kind,
  output logic [7:0]            out_out_byte,
  output logic [15:0]           out_frame_length,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [31:0]           pwdata,
  output logic [31:0]           prdata,
  output logic                  pready
);

  logic        out_ready;
  logic        res_load;
  result_t     res;
  logic [15:0] max_len;

  mlcd_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .max_len (max_len)
  );

  mlcd_core u_core (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_rx_byte   (in_rx_byte),
    .in_link_down (in_link_down),
    .max_len      (max_len),
    .out_ready    (out_ready),
    .res_load     (res_load),
    .res          (res)
  );

  mlcd_out u_out (
    .clk              (clk),
    .rst_n            (rst_n),
    .res_load         (res_load),
    .res              (res),
    .out_ready        (out_ready),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_event_kind   (out_event_kind),
    .out_out_byte     (out_out_byte),
    .out_frame_length (out_frame_length)
  );

endmodule

FILE: tb/sv/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for magic_length_crc8_deframer. A driver streams bytes
// with random gaps, and a monitor accepts events under random stall. Each
// accepted byte runs through a local copy of the sync/length/CRC-8 state
// machine, and every event is compared field by field with the one predicted.
// The maximum-length register is set to several values between traffic phases.
// ----------------------------------------------------------------------------
module tb;
  import mlcd_pkg::*;

  localparam int HALF_PERIOD  = 6;
  localparam int STALL_LIMIT  = 2000;
  localparam int DRAIN_CYCLES = 8;
  localparam int QUIET_FIRST  = 300;
  localparam int QUIET_LAST   = 800;
  localparam int PHASE_BYTES  = 110;

  typedef struct packed {
    logic [7:0] rx;
    logic       down;
  } rx_item_t;

  logic                  clk          = 1'b0;
  logic                  rst_n        = 1'b0;
  logic                  in_valid     = 1'b0;
  logic                  in_stall;
  logic [7:0]            in_rx_byte   = 8'h00;
  logic                  in_link_down = 1'b0;
  logic                  out_valid;
  logic                  out_stall    = 1'b0;
  logic [1:0]            out_event_kind;
  logic [7:0]            out_out_byte;
  logic [15:0]           out_frame_length;
  logic                  psel         = 1'b0;
  logic                  penable      = 1'b0;
  logic                  pwrite       = 1'b0;
  logic [CFG_ADDR_W-1:0] paddr        = '0;
  logic [31:0]           pwdata       = 32'h0;
  logic [31:0]           prdata;
  logic                  pready;

  // local copy of the deframer state and its register
  phase_t      rx_phase  = PH_HUNT0;
  logic [7:0]  len_lo    = 8'h00;
  logic [15:0] cur_len   = 16'h0;
  logic [15:0] left      = 16'h0;
  logic [7:0]  crc_acc   = 8'h00;
  logic [15:0] max_len   = MAX_LEN_RESET;

  rx_item_t    rx_pending[$];
  result_t     due_events[$];
  bit          in_taken     = 1'b0;
  int          cyc          = 0;
  int          idle_run     = 0;
  int          n_pushed     = 0;
  int          n_accepted   = 0;
  int          n_counted    = 0;
  int          fail_count   = 0;
  int          n_bytes_seen = 0;
  int          n_good       = 0;
  int          n_crc_bad    = 0;
  int          n_too_long   = 0;
  int          n_settings   = 1;

  magic_length_crc8_deframer dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_rx_byte       (in_rx_byte),
    .in_link_down     (in_link_down),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_event_kind   (out_event_kind),
    .out_out_byte     (out_out_byte),
    .out_frame_length (out_frame_length),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready)
  );

  always begin
    #HALF_PERIOD clk = 1'b1;
    #HALF_PERIOD clk = 1'b0;
  end

  // bit-serial form of the MSB-first CRC-8 update
  function automatic logic [7:0] crc8_next(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] r;
    logic       fb;
    r = crc;
    for (int i = 7; i >= 0; i--) begin
      fb = r[7] ^ b[i];
      r  = {r[6:0], 1'b0} ^ (fb ? CRC_POLY : 8'h00);
    end
    return r;
  endfunction

  function automatic bit take_break();
    return (cyc < QUIET_FIRST || cyc >= QUIET_LAST) && ($urandom_range(99) < 12);
  endfunction

  // advance the local deframer by one accepted byte and queue its event
  function void track_byte(input logic [7:0] b, input logic down);
    result_t ev;
    bit      emit;
    emit    = 1'b0;
    ev.kind = EV_BYTE;
    ev.data = 8'h00;
    ev.len  = 16'h0;
    if (down) begin
      rx_phase = PH_HUNT0;
    end else begin
      case (rx_phase)
        PH_HUNT1: begin
          if (b == SYNC_SECOND) rx_phase = PH_LEN_LO;
          else if (b == SYNC_FIRST) rx_phase = PH_HUNT1;
          else rx_phase = PH_HUNT0;
        end
        PH_LEN_LO: begin
          len_lo   = b;
          crc_acc  = crc8_next(8'h00, b);
          rx_phase = PH_LEN_HI;
        end
        PH_LEN_HI: begin
          cur_len = {b, len_lo};
          crc_acc = crc8_next(crc_acc, b);
          if (cur_len > max_len) begin
            ev.kind  = EV_TOO_LONG;
            emit     = 1'b1;
            rx_phase = PH_HUNT0;
          end else begin
            left = cur_len;
            if (cur_len == 16'h0) rx_phase = PH_CRC;
            else rx_phase = PH_PAYLOAD;
          end
        end
        PH_PAYLOAD: begin
          crc_acc = crc8_next(crc_acc, b);
          left    = left - 16'd1;
          if (left == 16'h0) rx_phase = PH_CRC;
          ev.kind = EV_BYTE;
          ev.data = b;
          emit    = 1'b1;
        end
        PH_CRC: begin
          if (b == crc_acc) ev.kind = EV_GOOD;
          else ev.kind = EV_CRC_BAD;
          emit     = 1'b1;
          rx_phase = PH_HUNT0;
        end
        default: begin
          if (b == SYNC_FIRST) rx_phase = PH_HUNT1;
          else rx_phase = PH_HUNT0;
        end
      endcase
    end
    if (emit) begin
      ev.len = cur_len;
      due_events.push_back(ev);
    end
  endfunction

  function void check_event();
    result_t want;
    if (due_events.size() == 0) begin
      $error("unexpected event: kind %0d byte %0h length %0d",
             out_event_kind, out_out_byte, out_frame_length);
      fail_count++;
    end else begin
      want = due_events.pop_front();
      if (out_event_kind !== want.kind) begin
        $error("event_kind: expected %0d, got %0d", want.kind, out_event_kind);
        fail_count++;
      end
      if (out_out_byte !== want.data) begin
        $error("out_byte: expected %0h, got %0h", want.data, out_out_byte);
        fail_count++;
      end
      if (out_frame_length !== want.len) begin
        $error("frame_length: expected %0d, got %0d", want.len, out_frame_length);
        fail_count++;
      end
      case (want.kind)
        EV_BYTE:    n_bytes_seen++;
        EV_GOOD:    n_good++;
        EV_CRC_BAD: n_crc_bad++;
        default:    n_too_long++;
      endcase
    end
  endfunction

  // driver: present the next byte, hold it until the transfer completes
  always @(negedge clk) begin
    rx_item_t item;
    out_stall <= take_break();
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (in_valid && !in_taken) begin
      // hold the stalled byte
    end else if (rx_pending.size() != 0 && !take_break()) begin
      item = rx_pending.pop_front();
      in_rx_byte   <= item.rx;
      in_link_down <= item.down;
      in_valid     <= 1'b1;
    end else begin
      in_valid <= 1'b0;
    end
  end

  // monitor: predict on input transfers, check on output transfers
  always @(posedge clk) begin
    bit got;
    cyc++;
    in_taken = rst_n && in_valid && !in_stall;
    got      = rst_n && out_valid && !out_stall;
    if (in_taken) begin
      track_byte(in_rx_byte, in_link_down);
      n_accepted++;
    end
    if (got) check_event();
    if (in_taken || got) idle_run = 0;
    else idle_run++;
    if (idle_run >= STALL_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  task automatic push_byte(input logic [7:0] b, input logic down = 1'b0);
    rx_item_t it;
    it.rx   = b;
    it.down = down;
    rx_pending.push_back(it);
    n_pushed++;
  endtask

  task automatic send_header(input logic [15:0] len);
    push_byte(SYNC_FIRST);
    push_byte(SYNC_SECOND);
    push_byte(len[7:0]);
    push_byte(len[15:8]);
    n_counted += 4;
  endtask

  // full frame; cut_at >= 0 drops the link in place of that payload byte
  task automatic send_frame(input logic [15:0] len, input bit bad_crc, input int cut_at);
    logic [7:0] crc;
    logic [7:0] b;
    send_header(len);
    crc = crc8_next(crc8_next(8'h00, len[7:0]), len[15:8]);
    for (int k = 0; k < int'(len); k++) begin
      if (k == cut_at) begin
        push_byte(8'($urandom_range(255)), 1'b1);
        return;
      end
      b = 8'($urandom_range(255));
      push_byte(b);
      crc = crc8_next(crc, b);
      n_counted++;
    end
    if (bad_crc) crc = crc ^ 8'($urandom_range(255, 1));
    push_byte(crc);
    n_counted++;
  endtask

  function automatic logic [15:0] pick_len();
    int cap;
    cap = int'(max_len);
    if ($urandom_range(99) < 85) begin
      if (cap > 12) cap = 12;
    end else if (cap > 48) begin
      cap = 48;
    end
    return 16'($urandom_range(cap));
  endfunction

  task automatic random_traffic(input int budget);
    int          start;
    int          pick;
    int          n;
    logic [15:0] len;
    start = n_counted;
    while (n_counted - start < budget) begin
      pick = $urandom_range(99);
      if (pick < 65) begin
        send_frame(pick_len(), $urandom_range(9) == 0, -1);
      end else if (pick < 75 && max_len != 16'hFFFF) begin
        if ($urandom_range(1)) len = max_len + 16'd1;
        else len = 16'($urandom_range(65535, int'(max_len) + 1));
        send_header(len);
      end else if (pick < 85) begin
        n = $urandom_range(4, 1);
        repeat (n) begin
          pick = $urandom_range(99);
          if (pick < 30) push_byte(SYNC_FIRST);
          else if (pick < 40) push_byte(SYNC_SECOND);
          else push_byte(8'($urandom_range(255)));
        end
      end else if (pick < 92) begin
        push_byte(8'($urandom_range(255)), 1'b1);
      end else if (max_len != 16'h0) begin
        len = pick_len();
        if (len == 16'h0) len = 16'd1;
        send_frame(len, 1'b0, $urandom_range(int'(len) - 1));
      end else begin
        push_byte(SYNC_FIRST);
        push_byte(SYNC_SECOND);
        push_byte(8'($urandom_range(255)), 1'b1);
      end
    end
  endtask

  // wait for every byte to transfer and every event to arrive, then settle
  task automatic wait_idle();
    while (n_accepted != n_pushed || due_events.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic cfg_access(input bit wr, input logic [15:0] value);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= CFG_MAX_LEN_ADDR;
    pwdata  <= {16'h0, value};
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (wr) begin
      max_len = value;
    end else if (prdata[15:0] !== max_len) begin
      $error("max_payload_length: expected %0d, got %0d", max_len, prdata[15:0]);
      fail_count++;
    end
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  initial begin
    logic [15:0] limits[4];
    repeat (5) @(negedge clk);
    rst_n <= 1'b1;
    cfg_access(1'b0, 16'h0);

    // directed: ignored byte on link drop, broken arm, run of sync-first bytes
    push_byte(SYNC_FIRST, 1'b1);
    push_byte(SYNC_FIRST);
    push_byte(8'h13);
    push_byte(SYNC_FIRST);
    push_byte(SYNC_FIRST);
    send_frame(16'd3, 1'b0, -1);
    send_frame(16'd0, 1'b0, -1);
    send_frame(16'd2, 1'b1, -1);
    // oversize header, then a stray second sync byte that must not arm
    send_header(MAX_LEN_RESET + 16'd1);
    push_byte(SYNC_SECOND);
    // length at the limit, aborted by a link drop
    send_frame(MAX_LEN_RESET, 1'b0, 2);
    // CRC byte equal to the first sync byte does not arm the hunt
    send_header(16'd1);
    push_byte(8'hFF);
    push_byte(SYNC_FIRST);
    push_byte(SYNC_SECOND);
    push_byte(8'h02);
    random_traffic(PHASE_BYTES);
    wait_idle();

    limits = '{16'h0, 16'hFFFF, 16'd7, 16'($urandom_range(60, 1))};
    foreach (limits[p]) begin
      cfg_access(1'b1, limits[p]);
      cfg_access(1'b0, 16'h0);
      n_settings++;
      if (limits[p] == 16'h0) begin
        send_frame(16'd0, 1'b0, -1);
        send_header(16'd1);
      end else if (limits[p] == 16'hFFFF) begin
        send_header(16'hFFFF);
        push_byte(8'h00, 1'b1);
      end
      random_traffic(PHASE_BYTES);
      wait_idle();
    end

    $display("checked %0d payload bytes, %0d good frames, %0d CRC errors, %0d oversize",
             n_bytes_seen, n_good, n_crc_bad, n_too_long);
    $display("from %0d input transfers under %0d length limits", n_accepted, n_settings);
    if (fail_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
